FILE: rtl/core/line_sensor_calibrate_detect_assert.svh
// ----------------------------------------------------------------------------
// Line sensor calibrate and detect: assertion macros
// Short forms for the concurrent checks used inside the block.
// ----------------------------------------------------------------------------
`ifndef LINE_SENSOR_CALIBRATE_DETECT_ASSERT_SVH
`define LINE_SENSOR_CALIBRATE_DETECT_ASSERT_SVH

// The consequent must hold in the same cycle as the antecedent.
`define LSCD_ASSERT_SAME(label, clk, rst_n, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// The consequent must hold in the cycle after the antecedent.
`define LSCD_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

FILE: rtl/core/lscd_pkg.sv
// ----------------------------------------------------------------------------
// Line sensor calibrate and detect: package
// Transaction types, command and register codes, and fixed constants.
// ----------------------------------------------------------------------------
package lscd_pkg;

  // Channel count and fixed field widths.
  localparam int NUM_CH     = 6;
  localparam int RAW_W      = 16;
  localparam int CFG_DATA_W = 16;
  localparam int RATIO_W    = 7;
  localparam int STR_W      = 7;
  localparam int CFG_IDX_W  = 1;
  localparam int PCT_SCALE  = 100;

  // Register reset values and limits.
  localparam logic [RATIO_W-1:0]    RATIO_RESET     = 7'd50;
  localparam logic [RATIO_W-1:0]    RATIO_MAX       = 7'd100;
  localparam logic [CFG_DATA_W-1:0] MIN_RANGE_RESET = 16'd10;
  localparam logic [STR_W-1:0]      STR_FULL        = 7'd100;

  // Command codes.
  localparam logic [1:0] CMD_PROCESS    = 2'd0;
  localparam logic [1:0] CMD_START_SCAN = 2'd1;
  localparam logic [1:0] CMD_STOP_SCAN  = 2'd2;

  // Configuration register indexes.
  localparam logic [CFG_IDX_W-1:0] REG_RATIO     = 1'b0;
  localparam logic [CFG_IDX_W-1:0] REG_MIN_RANGE = 1'b1;

  // Converter slot feeding each channel: front, right front, right back,
  // back, left back, left front.
  localparam logic [2:0] SLOT_OF_CHAN [NUM_CH] = '{3'd1, 3'd5, 3'd4, 3'd3, 3'd0, 3'd2};

  // Input transaction.
  typedef struct packed {
    logic [1:0]       cmd;
    logic [RAW_W-1:0] raw_0;
    logic [RAW_W-1:0] raw_1;
    logic [RAW_W-1:0] raw_2;
    logic [RAW_W-1:0] raw_3;
    logic [RAW_W-1:0] raw_4;
    logic [RAW_W-1:0] raw_5;
  } lscd_in_t;

  // Result transaction.
  typedef struct packed {
    logic [NUM_CH-1:0] line_mask;
    logic              any_on_line;
    logic [STR_W-1:0]  strength_front;
    logic [STR_W-1:0]  strength_right_front;
    logic [STR_W-1:0]  strength_right_back;
    logic [STR_W-1:0]  strength_back;
    logic [STR_W-1:0]  strength_left_back;
    logic [STR_W-1:0]  strength_left_front;
    logic              scanning;
    logic              calibrated;
  } lscd_out_t;

  // Sequencer states.
  typedef enum logic [2:0] {
    ST_IDLE,
    ST_UPDATE,
    ST_MUL,
    ST_TDIV,
    ST_SLOAD,
    ST_SDIV,
    ST_DONE
  } lscd_state_t;

endpackage

FILE: rtl/core/line_sensor_calibrate_detect.sv
// ----------------------------------------------------------------------------
// Line sensor calibrate and detect
// Six-channel reflectance line sensor with min/max calibration, per-channel
// thresholds and 0..100 strengths, computed in six bit-serial lanes.
// ----------------------------------------------------------------------------
// The block takes one transaction at a time and returns one result for each.
// A process transaction passes through the update state alone while uncalibrated;
// while calibrated it also runs the seven-step restoring divide that forms each
// strength (all six channels in parallel). A start scan passes through the update
// state alone. A stop scan that ends an active scan runs a seven-step serial
// multiply by the threshold ratio, a SAMPLE_BITS-step divide by 100, then the
// strength divide, or skips the strength divide when no channel has a valid range.
// A result that is not taken holds the block in its final state until the output
// register frees. Configuration writes go straight to their registers.
// ----------------------------------------------------------------------------

`include "line_sensor_calibrate_detect_assert.svh"

module line_sensor_calibrate_detect #(
  parameter int SAMPLE_BITS = 16
) (
  input  logic                                clk,
  input  logic                                rst_n,
  // Input channel
  input  logic                                in_valid,
  output logic                                in_ready,
  input  lscd_pkg::lscd_in_t                  in_data,
  // Result channel
  output logic                                out_valid,
  input  logic                                out_ready,
  output lscd_pkg::lscd_out_t                 out_data,
  // Configuration port
  input  logic                                cfg_wr_en,
  input  logic [lscd_pkg::CFG_IDX_W-1:0]      cfg_index,
  input  logic [lscd_pkg::CFG_DATA_W-1:0]     cfg_wdata
);

  localparam int SB = SAMPLE_BITS;
  localparam int PW = SB + lscd_pkg::RATIO_W;
  localparam int CW = $clog2(SB);
  localparam int NC = lscd_pkg::NUM_CH;
  localparam logic [CW-1:0] MUL_INIT  = CW'(lscd_pkg::RATIO_W - 1);
  localparam logic [CW-1:0] TDIV_INIT = CW'(SB - 1);
  localparam logic [CW-1:0] SDIV_INIT = CW'(lscd_pkg::STR_W - 1);

  // Sequencer and control registers.
  lscd_pkg::lscd_state_t              state_r, state_nxt;
  logic [1:0]                         cmd_r;
  logic [CW-1:0]                      cnt_r;
  logic [lscd_pkg::RATIO_W-1:0]       ratio_r;
  logic [lscd_pkg::CFG_DATA_W-1:0]    mvr_r;
  logic [lscd_pkg::RATIO_W-1:0]       ratio_sr_r;
  logic [NC-1:0]                      mask_r;
  logic                               on_any_r;
  logic                               scan_r;
  logic                               cal_r;
  logic                               out_valid_r;
  lscd_pkg::lscd_out_t                out_data_r;

  // Per-channel lane registers.
  logic [SB-1:0]                      samp_r  [NC];
  logic [SB-1:0]                      min_r   [NC];
  logic [SB-1:0]                      max_r   [NC];
  logic [SB-1:0]                      thr_r   [NC];
  logic [lscd_pkg::STR_W-1:0]         str_r   [NC];
  logic [PW-1:0]                      prod_r  [NC];
  logic [SB-1:0]                      rem_r   [NC];
  logic [SB-1:0]                      dsr_r   [NC];
  logic [SB-1:0]                      quo_r   [NC];
  logic [SB-1:0]                      div_r   [NC];

  // Lane status.
  logic [NC-1:0]                      lane_vld;
  logic [NC-1:0]                      lane_on;
  logic                               any_vld;

  // Control strobes.
  logic in_fire;
  logic seed, widen, clr_det, stop_go;
  logic mul_step, mul_last, div_step, tdiv_last, s_load, sdiv_last, out_load;

  // Samples in converter slot order, cut to the sample width.
  logic [SB-1:0] raw_slot [NC];

  assign raw_slot[0] = in_data.raw_0[SB-1:0];
  assign raw_slot[1] = in_data.raw_1[SB-1:0];
  assign raw_slot[2] = in_data.raw_2[SB-1:0];
  assign raw_slot[3] = in_data.raw_3[SB-1:0];
  assign raw_slot[4] = in_data.raw_4[SB-1:0];
  assign raw_slot[5] = in_data.raw_5[SB-1:0];

  assign in_fire = in_valid && in_ready;
  assign any_vld = |lane_vld;

  // Sequencer state register.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= lscd_pkg::ST_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  // Next state and control strobes.
  always_comb begin
    state_nxt = state_r;
    in_ready  = 1'b0;
    seed      = 1'b0;
    widen     = 1'b0;
    clr_det   = 1'b0;
    stop_go   = 1'b0;
    mul_step  = 1'b0;
    mul_last  = 1'b0;
    div_step  = 1'b0;
    tdiv_last = 1'b0;
    s_load    = 1'b0;
    sdiv_last = 1'b0;
    out_load  = 1'b0;
    unique case (state_r)
      lscd_pkg::ST_IDLE: begin
        in_ready = 1'b1;
        if (in_valid) begin
          state_nxt = lscd_pkg::ST_UPDATE;
        end
      end
      lscd_pkg::ST_UPDATE: begin
        unique case (cmd_r)
          lscd_pkg::CMD_PROCESS: begin
            widen = scan_r;
            if (cal_r) begin
              state_nxt = lscd_pkg::ST_SLOAD;
            end else begin
              clr_det   = 1'b1;
              state_nxt = lscd_pkg::ST_DONE;
            end
          end
          lscd_pkg::CMD_START_SCAN: begin
            seed      = 1'b1;
            clr_det   = 1'b1;
            state_nxt = lscd_pkg::ST_DONE;
          end
          lscd_pkg::CMD_STOP_SCAN: begin
            if (scan_r) begin
              stop_go   = 1'b1;
              state_nxt = lscd_pkg::ST_MUL;
            end else begin
              state_nxt = lscd_pkg::ST_DONE;
            end
          end
          default: begin
            state_nxt = lscd_pkg::ST_DONE;
          end
        endcase
      end
      lscd_pkg::ST_MUL: begin
        mul_step = 1'b1;
        if (cnt_r == '0) begin
          mul_last  = 1'b1;
          state_nxt = lscd_pkg::ST_TDIV;
        end
      end
      lscd_pkg::ST_TDIV: begin
        div_step = 1'b1;
        if (cnt_r == '0) begin
          tdiv_last = 1'b1;
          if (any_vld) begin
            state_nxt = lscd_pkg::ST_SLOAD;
          end else begin
            clr_det   = 1'b1;
            state_nxt = lscd_pkg::ST_DONE;
          end
        end
      end
      lscd_pkg::ST_SLOAD: begin
        s_load    = 1'b1;
        state_nxt = lscd_pkg::ST_SDIV;
      end
      lscd_pkg::ST_SDIV: begin
        div_step = 1'b1;
        if (cnt_r == '0) begin
          sdiv_last = 1'b1;
          state_nxt = lscd_pkg::ST_DONE;
        end
      end
      lscd_pkg::ST_DONE: begin
        if (!out_valid_r || out_ready) begin
          out_load  = 1'b1;
          state_nxt = lscd_pkg::ST_IDLE;
        end
      end
      default: begin
        state_nxt = lscd_pkg::ST_IDLE;
      end
    endcase
  end

  // Shared control registers, configuration and flags.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      ratio_r  <= lscd_pkg::RATIO_RESET;
      mvr_r    <= lscd_pkg::MIN_RANGE_RESET;
      mask_r   <= '0;
      on_any_r <= 1'b0;
      scan_r   <= 1'b0;
      cal_r    <= 1'b0;
      cnt_r    <= '0;
    end else begin
      // Register writes.
      if (cfg_wr_en) begin
        unique case (cfg_index)
          lscd_pkg::REG_RATIO:     ratio_r <= cfg_wdata[lscd_pkg::RATIO_W-1:0];
          lscd_pkg::REG_MIN_RANGE: mvr_r   <= cfg_wdata;
          default: ;
        endcase
      end

      // Step counter for the serial multiply and divides.
      if (stop_go) begin
        cnt_r <= MUL_INIT;
      end else if (mul_last) begin
        cnt_r <= TDIV_INIT;
      end else if (s_load) begin
        cnt_r <= SDIV_INIT;
      end else if (mul_step || div_step) begin
        cnt_r <= cnt_r - 1'b1;
      end

      // Scan and calibration flags.
      if (seed) begin
        scan_r <= 1'b1;
        cal_r  <= 1'b0;
      end else if (stop_go) begin
        scan_r <= 1'b0;
      end
      if (tdiv_last) begin
        cal_r <= any_vld;
      end

      // Detection outputs.
      if (clr_det) begin
        mask_r   <= '0;
        on_any_r <= 1'b0;
      end else if (sdiv_last) begin
        mask_r   <= lane_on;
        on_any_r <= |lane_on;
      end
    end
  end

  // Command capture and the ratio shifted out one bit per multiply step.
  always_ff @(posedge clk) begin
    if (in_fire) begin
      cmd_r <= in_data.cmd;
    end
    if (stop_go) begin
      ratio_sr_r <= (ratio_r > lscd_pkg::RATIO_MAX) ? lscd_pkg::RATIO_MAX : ratio_r;
    end else if (mul_step) begin
      ratio_sr_r <= {ratio_sr_r[lscd_pkg::RATIO_W-2:0], 1'b0};
    end
  end

  // Six channel lanes, each with a shift-add multiplier and a restoring divider.
  for (genvar i = 0; i < NC; i++) begin : g_lane
    logic [SB-1:0] rng;
    logic          max_ge_min;
    logic [SB-1:0] diff;
    logic [PW-1:0] dnum;
    logic [PW-1:0] prod_nxt;
    logic [SB:0]   rem_sh;
    logic [SB:0]   rem_sub;
    logic          q_bit;
    logic [SB-1:0] rem_nxt;
    logic [SB-1:0] quo_nxt;
    logic [lscd_pkg::STR_W-1:0] str_val;

    // Range check against the minimum valid range.
    always_comb begin
      max_ge_min  = max_r[i] >= min_r[i];
      rng         = max_r[i] - min_r[i];
      lane_vld[i] = max_ge_min && (lscd_pkg::CFG_DATA_W'(rng) > mvr_r);
      lane_on[i]  = lane_vld[i] && (samp_r[i] >= thr_r[i]);
    end

    // Strength numerator: (sample - min) * 100 by shifts and adds.
    always_comb begin
      diff = samp_r[i] - min_r[i];
      dnum = (PW'(diff) << 6) + (PW'(diff) << 5) + (PW'(diff) << 2);
    end

    // One multiply step: accumulate the range for each ratio bit, MSB first.
    assign prod_nxt = (prod_r[i] << 1)
                    + (ratio_sr_r[lscd_pkg::RATIO_W-1] ? PW'(rng) : '0);

    // One divide step: bring in the next dividend bit and try a subtract.
    always_comb begin
      rem_sh  = {rem_r[i], dsr_r[i][SB-1]};
      rem_sub = rem_sh - {1'b0, div_r[i]};
      q_bit   = rem_sh >= {1'b0, div_r[i]};
      rem_nxt = q_bit ? rem_sub[SB-1:0] : rem_sh[SB-1:0];
      quo_nxt = {quo_r[i][SB-2:0], q_bit};
    end

    // Final strength, clamped to full scale.
    always_comb begin
      if (!lane_vld[i] || (samp_r[i] <= min_r[i])) begin
        str_val = '0;
      end else if (diff >= rng) begin
        str_val = lscd_pkg::STR_FULL;
      end else begin
        str_val = quo_nxt[lscd_pkg::STR_W-1:0];
      end
    end

    // Calibration state of the lane.
    always_ff @(posedge clk) begin
      if (!rst_n) begin
        min_r[i] <= '1;
        max_r[i] <= '0;
        thr_r[i] <= '0;
        str_r[i] <= '0;
      end else begin
        if (seed) begin
          min_r[i] <= samp_r[i];
          max_r[i] <= samp_r[i];
          thr_r[i] <= '0;
        end else if (widen) begin
          if (samp_r[i] < min_r[i]) begin
            min_r[i] <= samp_r[i];
          end
          if (samp_r[i] > max_r[i]) begin
            max_r[i] <= samp_r[i];
          end
        end else if (tdiv_last) begin
          thr_r[i] <= lane_vld[i] ? (min_r[i] + quo_nxt) : '0;
        end
        if (clr_det) begin
          str_r[i] <= '0;
        end else if (sdiv_last) begin
          str_r[i] <= str_val;
        end
      end
    end

    // Sample capture, multiply accumulator and divider datapath.
    always_ff @(posedge clk) begin
      if (in_fire) begin
        samp_r[i] <= raw_slot[lscd_pkg::SLOT_OF_CHAN[i]];
      end
      if (stop_go) begin
        prod_r[i] <= '0;
      end else if (mul_step) begin
        prod_r[i] <= prod_nxt;
      end
      if (mul_last) begin
        rem_r[i] <= SB'(prod_nxt[PW-1:SB]);
        dsr_r[i] <= prod_nxt[SB-1:0];
        div_r[i] <= SB'(lscd_pkg::PCT_SCALE);
        quo_r[i] <= '0;
      end else if (s_load) begin
        rem_r[i] <= dnum[PW-1:lscd_pkg::STR_W];
        dsr_r[i] <= {dnum[lscd_pkg::STR_W-1:0], {(SB - lscd_pkg::STR_W){1'b0}}};
        div_r[i] <= rng;
        quo_r[i] <= '0;
      end else if (div_step) begin
        rem_r[i] <= rem_nxt;
        dsr_r[i] <= {dsr_r[i][SB-2:0], 1'b0};
        quo_r[i] <= quo_nxt;
      end
    end
  end

  // Output register: loaded in the final state, freed when the result is taken.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (out_load) begin
      out_valid_r <= 1'b1;
    end else if (out_ready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (out_load) begin
      out_data_r.line_mask            <= mask_r;
      out_data_r.any_on_line          <= on_any_r;
      out_data_r.strength_front       <= str_r[0];
      out_data_r.strength_right_front <= str_r[1];
      out_data_r.strength_right_back  <= str_r[2];
      out_data_r.strength_back        <= str_r[3];
      out_data_r.strength_left_back   <= str_r[4];
      out_data_r.strength_left_front  <= str_r[5];
      out_data_r.scanning             <= scan_r;
      out_data_r.calibrated           <= cal_r;
    end
  end

  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

  // A scan always clears calibration, and ending one clears scanning.
  `LSCD_ASSERT_SAME(a_scan_cal_excl, clk, rst_n, scan_r, !cal_r, "scanning while calibrated")
  // The any-on-line flag always agrees with the mask.
  `LSCD_ASSERT_SAME(a_any_mask, clk, rst_n, 1'b1, on_any_r == (mask_r != '0), "any flag mismatch")
  // An accepted transaction always starts its update in the next cycle.
  `LSCD_ASSERT_NEXT(a_accept_update, clk, rst_n, in_fire, state_r == lscd_pkg::ST_UPDATE, "no update after accept")
  // Leaving the final state always presents a result.
  `LSCD_ASSERT_NEXT(a_done_result, clk, rst_n, out_load, out_valid_r && (state_r == lscd_pkg::ST_IDLE), "result not presented")

endmodule
